FILE: rtl/assert_macros.svh
// Assertion macros shared by the voice RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define SVR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SVR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/svr_pkg.sv
// Types, constants and table helpers for the sine voice.
package svr_pkg;

  localparam int unsigned SINE_ENTRIES_DEF = 1024;
  localparam int unsigned SAMPLE_BITS      = 16;

  localparam logic [31:0] A4_STEP_RESET = 32'd39370534;

  // Gains are Q1.16.
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] TAIL_MUL  = 17'd65208;
  localparam logic [16:0] TAIL_STOP = 17'd65;

  // Q16 magnitude to output fraction bits.
  localparam int unsigned RSH  = (SAMPLE_BITS <= 17) ? 17 - SAMPLE_BITS : 0;
  localparam int unsigned LSH  = (SAMPLE_BITS > 17) ? SAMPLE_BITS - 17 : 0;
  localparam int unsigned MAGW = 17 + LSH;
  localparam logic [MAGW-1:0] MAX_POS = MAGW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  // Shared multiplier shape.
  localparam int unsigned MUL_AW = 32;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // 2^(k/12) in Q16.
  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  // Word index of the register file.
  localparam logic REG_A4_STEP = 1'b0;

  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_TICK     = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  note;
    logic [16:0] velocity;
    logic        allow_tail_off;
  } svr_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          active;
  } svr_res_t;

  typedef enum logic [2:0] {
    MUL_IDX   = 3'd0,
    MUL_STEP  = 3'd1,
    MUL_LVL   = 3'd2,
    MUL_TAIL  = 3'd3,
    MUL_DECAY = 3'd4
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_en;
    logic    load_req;
    logic    rom_rd;
    logic    mag_first;
    logic    mag_tail;
    logic    note_on;
    logic    note_off;
    logic    finish;
  } svr_cmd_t;

  typedef struct packed {
    logic step_zero;
  } svr_stat_t;

  // Elaboration-time helpers for the sine table.
  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] prod;
    prod = a * b;
    return prod >> 30;
  endfunction

  // sin(pi/2 * u), u and result Q30.
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] p;
    u2 = mul_q30(u, u);
    p  = 64'd3864;
    p  = 64'd172272 - mul_q30(u2, p);
    p  = 64'd5026995 - mul_q30(u2, p);
    p  = 64'd85569306 - mul_q30(u2, p);
    p  = 64'd693598668 - mul_q30(u2, p);
    p  = 64'd1686629713 - mul_q30(u2, p);
    return mul_q30(u, p);
  endfunction

endpackage

FILE: rtl/svr_ctrl.sv
// Sequencer for the sine voice: request decode, multiplier schedule, result slot.
`include "assert_macros.svh"

module svr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  svr_pkg::svr_stat_t stat,
  output svr_pkg::svr_cmd_t  cmd
);
  import svr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ROM     = 9'b000000010,
    S_LVL     = 9'b000000100,
    S_TAIL    = 9'b000001000,
    S_DECAY   = 9'b000010000,
    S_FIN     = 9'b000100000,
    S_STEP    = 9'b001000000,
    S_STEP_WR = 9'b010000000,
    S_OFF     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = MUL_IDX;
    unique case (state)
      S_IDLE: begin
        cmd.mul_en   = 1'b1;
        cmd.load_req = 1'b1;
        if (req_valid) begin
          case (req_type)
            REQ_NOTE_ON:  state_next = S_STEP;
            REQ_NOTE_OFF: state_next = S_OFF;
            REQ_TICK:     state_next = stat.step_zero ? S_FIN : S_ROM;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_ROM: begin
        cmd.rom_rd = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LVL;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = MUL_TAIL;
        cmd.mag_first = 1'b1;
        state_next    = S_DECAY;
      end
      S_DECAY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_DECAY;
        cmd.mag_tail = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        // hold until the result slot is free
        if (!res_valid || res_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STEP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_STEP;
        state_next = S_STEP_WR;
      end
      S_STEP_WR: begin
        cmd.note_on = 1'b1;
        state_next  = S_IDLE;
      end
      S_OFF: begin
        cmd.note_off = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.finish) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  `SVR_ASSERT_NEXT(a_finish_loads_slot, clk, rst, cmd.finish, res_valid, "finished tick not presented")
  `SVR_ASSERT_NEXT(a_fin_waits, clk, rst, (state == S_FIN) && res_valid && !res_ready, state == S_FIN, "result slot overrun")

endmodule

FILE: rtl/svr_datapath.sv
// Voice state, shared multiplier, sine ROM and result register.
`include "assert_macros.svh"

module svr_datapath #(
  parameter int unsigned SINE_ENTRIES = svr_pkg::SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        a4_step,
  input  svr_pkg::svr_req_t  req,
  input  svr_pkg::svr_cmd_t  cmd,
  output svr_pkg::svr_stat_t stat,
  output svr_pkg::svr_res_t  res
);
  import svr_pkg::*;

  localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);

  // Entry: sign bit over a 17-bit Q16 magnitude.
  typedef logic [17:0] sine_arr_t [SINE_ENTRIES];

  function automatic sine_arr_t build_sine();
    sine_arr_t   tab;
    logic [63:0] pos;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] q16;
    logic [1:0]  quad;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      pos  = 64'(i) * 64'd4;
      quad = 2'(pos / SINE_ENTRIES);
      u    = ((pos % SINE_ENTRIES) << 30) / SINE_ENTRIES;
      if (quad[0]) begin
        u = ONE_Q30 - u;
      end
      s   = quarter_sine(u);
      q16 = (s + 64'd8192) >> 14;
      if (q16 > 64'd65536) begin
        q16 = 64'd65536;
      end
      tab[i] = {quad[1] && (q16 != 64'd0), q16[16:0]};
    end
    return tab;
  endfunction

  localparam sine_arr_t SINE_TAB = build_sine();

  // Architectural state
  logic [31:0] phase;
  logic [31:0] phase_step;
  logic [16:0] level;
  logic [16:0] tail;

  // Working registers
  svr_req_t          req_q;
  logic [MUL_PW-1:0] mul_p;
  logic [17:0]       rom_q;
  logic [16:0]       mag;
  svr_res_t          res_q;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;

  logic [7:0]        note_e;
  logic [15:0]       oct_prod;
  logic [3:0]        octv;
  logic [3:0]        semi;
  logic [4:0]        shamt;
  logic [MUL_PW-1:0] step_full;
  logic [31:0]       step_sat;
  logic [16:0]       vel_clamp;

  logic [IDX_W-1:0]  idx;
  logic [16:0]       prod_q16;
  logic              releasing;
  logic              silent;
  logic              stop;
  logic              neg;
  logic [MAGW-1:0]   mag_w;
  logic [MAGW-1:0]   mag_sat;
  logic [SAMPLE_BITS-1:0] mag_sb;
  logic [SAMPLE_BITS-1:0] sample_val;

  // Note number to semitone and octave: e / 12 by reciprocal, e below 131.
  always_comb begin
    note_e    = {1'b0, req_q.note} + 8'd3;
    oct_prod  = 16'(note_e) * 16'd171;
    octv      = oct_prod[14:11];
    semi      = 4'(note_e - 8'(octv) * 8'd12);
    shamt     = 5'd22 - 5'(octv);
    step_full = mul_p >> shamt;
    if (|step_full[MUL_PW-1:32]) begin
      step_sat = '1;
    end else if (step_full[31:0] == 32'd0) begin
      step_sat = 32'd1;
    end else begin
      step_sat = step_full[31:0];
    end
    vel_clamp = (req_q.velocity > ONE_Q16) ? ONE_Q16 : req_q.velocity;
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_IDX: begin
        mul_a = phase;
        mul_b = MUL_BW'(SINE_ENTRIES);
      end
      MUL_STEP: begin
        mul_a = a4_step;
        mul_b = SEMITONE_Q16[semi];
      end
      MUL_LVL: begin
        mul_a = MUL_AW'(rom_q[16:0]);
        mul_b = level;
      end
      MUL_TAIL: begin
        mul_a = MUL_AW'(mul_p[32:16]);
        mul_b = tail;
      end
      MUL_DECAY: begin
        mul_a = MUL_AW'(tail);
        mul_b = TAIL_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    idx       = mul_p[32 +: IDX_W];
    prod_q16  = mul_p[32:16];
    releasing = (tail != 17'd0);
    silent    = (phase_step == 32'd0);
    stop      = releasing && (prod_q16 <= TAIL_STOP);
    neg       = rom_q[17];
    mag_w     = (MAGW'(mag) >> RSH) << LSH;
    mag_sat   = (!neg && (mag_w > MAX_POS)) ? MAX_POS : mag_w;
    mag_sb    = mag_sat[SAMPLE_BITS-1:0];
    sample_val = neg ? (~mag_sb + SAMPLE_BITS'(1)) : mag_sb;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.mul_en) begin
      mul_p <= MUL_PW'(mul_a) * MUL_PW'(mul_b);
    end
    if (cmd.rom_rd) begin
      rom_q <= SINE_TAB[idx];
    end
    if (cmd.mag_first) begin
      mag <= prod_q16;
    end else if (cmd.mag_tail && releasing) begin
      mag <= prod_q16;
    end
    if (cmd.finish) begin
      if (silent || stop) begin
        res_q.sample <= '0;
        res_q.active <= 1'b0;
      end else begin
        res_q.sample <= signed'(sample_val);
        res_q.active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      level      <= '0;
      tail       <= '0;
    end else if (cmd.note_on) begin
      phase      <= '0;
      phase_step <= step_sat;
      level      <= vel_clamp;
      tail       <= '0;
    end else if (cmd.note_off) begin
      if (req_q.allow_tail_off && !silent) begin
        tail <= ONE_Q16;
      end else begin
        phase_step <= '0;
        tail       <= '0;
      end
    end else if (cmd.finish && !silent) begin
      if (stop) begin
        phase_step <= '0;
        tail       <= '0;
      end else begin
        phase <= phase + phase_step;
        if (releasing) begin
          tail <= prod_q16;
        end
      end
    end
  end

  assign stat.step_zero = silent;
  assign res            = res_q;

  `SVR_ASSERT_IMPL(a_silent_no_tail, clk, rst, phase_step == 32'd0, tail == 17'd0, "tail left on silent voice")
  `SVR_ASSERT_IMPL(a_gain_range, clk, rst, 1'b1, (level <= ONE_Q16) && (tail <= ONE_Q16), "gain above unity")

endmodule

FILE: rtl/sine_voice_with_release_top.sv
// Top level of the sine voice: register port, sequencer and datapath.
// One synthesizer voice. A request beat is a note-on (req_type 0: phase to zero, level from
// velocity clamped to 1.0, release cleared, phase step a4_step * 2^((note-69)/12)), a note-off
// (req_type 1: start a release at 1.0 if allowed and the voice sounds, else silence it) or a
// tick (req_type 2), which alone returns a result beat: sample = sine(phase) * level (* tail
// while releasing) as signed Q1.(SAMPLE_BITS-1), plus active. The release tail shrinks by
// 0.995 per tick and the voice stops, giving a zero sample, once it reaches 0.001. Code 3 is
// dropped. One item is in flight at a time. A sounding tick steps the sequencer through idle,
// ROM read, level, tail, decay and finish states and loads the result register as it leaves
// finish; a silent tick goes from idle straight to finish, a note-on through step and
// step-write, a note-off through off; finish holds while the previous result still waits.
// The sequence is set by the single shared 32x17 multiplier, which runs the phase-to-index,
// level, tail and decay products in turn, and by the registered sine ROM read. The result
// register lets the next request be taken while a result beat waits for res_ready. Register
// map: a4_step, the 32-bit phase step for 440 Hz, at byte address 0 (reset 39370534); pready
// is always high.
module sine_voice_with_release_top #(
  parameter int unsigned SINE_ENTRIES = svr_pkg::SINE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  svr_pkg::svr_req_t req,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output svr_pkg::svr_res_t res
);
  import svr_pkg::*;

  logic [31:0] a4_step;
  svr_cmd_t    cmd;
  svr_stat_t   stat;

  assign pready = 1'b1;

  // Register write lands in the access phase; other word addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      a4_step <= A4_STEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_A4_STEP)) begin
      a4_step <= pwdata;
    end
  end

  // Read back the step register; unmapped words read as zero.
  assign prdata = (paddr[2] == REG_A4_STEP) ? a4_step : 32'd0;

  svr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  svr_datapath #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .a4_step (a4_step),
    .req     (req),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

endmodule
